### design/scq_pkg.sv
// Package with the types, codes and constants of the send completion queue.
`default_nettype none
package scq_pkg;
    localparam int RingDepthDefault = 16;
    localparam int MaxResults = 16;

    localparam logic [2:0] ACT_ENQUEUE = 3'd0;
    localparam logic [2:0] ACT_FETCH = 3'd1;
    localparam logic [2:0] ACT_CONFIRM = 3'd2;
    localparam logic [2:0] ACT_CANCEL = 3'd3;
    localparam logic [2:0] ACT_TICK = 3'd4;

    localparam logic [2:0] RS_FETCHED = 3'd0;
    localparam logic [2:0] RS_NOTHING = 3'd1;
    localparam logic [2:0] RS_COMPLETED = 3'd2;
    localparam logic [2:0] RS_ABORTED = 3'd3;
    localparam logic [2:0] RS_PAUSED = 3'd4;
    localparam logic [2:0] RS_ACCEPTED = 3'd5;
    localparam logic [2:0] RS_FULL = 3'd6;
    localparam logic [2:0] RS_IGNORED = 3'd7;

    typedef enum logic [2:0] {
        SL_EMPTY = 3'd0,
        SL_READY = 3'd1,
        SL_PENDING = 3'd2,
        SL_SENT = 3'd3,
        SL_CANCEL = 3'd4
    } slot_st_t;

    typedef enum logic [2:0] {
        CMD_ENQUEUE,
        CMD_FETCH,
        CMD_CONFIRM,
        CMD_CANCEL,
        CMD_TICK,
        CMD_BAD
    } cmd_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_FETCH,
        S_CONFIRM,
        S_CANCEL,
        S_RETIRE,
        S_DROP,
        S_BAD
    } back_st_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic [7:0] group_tag;
        logic [7:0] cancel_tag;
        logic end_of_group;
        logic [3:0] slot_id;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot_index;
        logic [7:0] packet_tag;
        logic [31:0] sent_total;
    } res_t;
endpackage
`default_nettype wire

### design/scq_in_if.sv
// Request channel of the send completion queue.
`default_nettype none
interface scq_in_if;
    logic valid;
    logic ready;
    logic [2:0] action;
    logic [7:0] group_tag;
    logic [7:0] cancel_tag;
    logic end_of_group;
    logic [3:0] slot_id;

    modport source (output valid, action, group_tag, cancel_tag, end_of_group, slot_id,
                    input ready);
    modport sink (input valid, action, group_tag, cancel_tag, end_of_group, slot_id,
                  output ready);
endinterface
`default_nettype wire

### design/scq_out_if.sv
// Result channel of the send completion queue.
`default_nettype none
interface scq_out_if;
    logic valid;
    logic ready;
    logic [2:0] status;
    logic [3:0] slot_index;
    logic [7:0] packet_tag;
    logic final_result;
    logic [31:0] sent_total;

    modport source (output valid, status, slot_index, packet_tag, final_result, sent_total,
                    input ready);
    modport sink (input valid, status, slot_index, packet_tag, final_result, sent_total,
                  output ready);
endinterface
`default_nettype wire

### design/scq_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none
module scq_front
    import scq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    scq_in_if.sink    req,
    output cmd_t      cmd,
    output logic      cmd_valid,
    input  wire logic cmd_pop
);
    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    cmd_t       new_cmd;

    assign req.ready = (count_reg != 2'd2);
    assign push = req.valid && req.ready;
    assign pop = cmd_pop && (count_reg != 2'd0);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        new_cmd.group_tag = req.group_tag;
        new_cmd.cancel_tag = req.cancel_tag;
        new_cmd.end_of_group = req.end_of_group;
        new_cmd.slot_id = req.slot_id;
        case (req.action)
            ACT_ENQUEUE: new_cmd.kind = CMD_ENQUEUE;
            ACT_FETCH:   new_cmd.kind = CMD_FETCH;
            ACT_CONFIRM: new_cmd.kind = CMD_CONFIRM;
            ACT_CANCEL:  new_cmd.kind = CMD_CANCEL;
            ACT_TICK:    new_cmd.kind = CMD_TICK;
            default:     new_cmd.kind = CMD_BAD;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_cmd;
        end
    end
endmodule
`default_nettype wire

### design/scq_back.sv
// Back end: ring state and the slot walker that executes queued requests.
`default_nettype none
module scq_back
    import scq_pkg::*;
#(
    parameter int RING_DEPTH = RingDepthDefault
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cmd_t      cmd,
    input  wire logic cmd_valid,
    output logic      cmd_pop,
    scq_out_if.source res
);
    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int NRES_W = $clog2(MaxResults + 1);

    back_st_t state_reg, state_next;
    cmd_t cmd_reg, cmd_next;
    slot_st_t status_reg [RING_DEPTH];
    slot_st_t status_next [RING_DEPTH];
    logic [7:0] group_mem [RING_DEPTH];
    logic [7:0] cancel_mem [RING_DEPTH];
    logic last_mem [RING_DEPTH];
    logic [PTR_W-1:0] oldest_reg, oldest_next, free_reg, free_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic fetched_reg, fetched_next;
    logic [31:0] sent_reg, sent_next;
    logic [PTR_W-1:0] pos_reg, pos_next, start_reg, start_next;
    logic [CNT_W-1:0] remain_reg, remain_next, len_reg, len_next;
    logic [7:0] gtag_reg, gtag_next, ctag_reg, ctag_next;
    logic all_sent_reg, all_sent_next, all_cancel_reg, all_cancel_next;
    logic all_ready_reg, all_ready_next;
    logic [RING_DEPTH-1:0] mask_reg, mask_next;
    logic [NRES_W-1:0] n_reg, n_next;
    res_t held_reg, held_next, out_reg, out_next;
    logic held_valid_reg, held_valid_next, held_final_reg, held_final_next;
    logic out_valid_reg, out_valid_next, out_final_reg, out_final_next;

    logic [PTR_W-1:0] rd_addr, pos_inc, free_inc, old_add;
    slot_st_t rd_status;
    logic [7:0] rd_group;
    logic [7:0] rd_cancel;
    logic rd_last;
    logic sid_ok, full, grp_end, walk_stop;
    logic [CNT_W-1:0] new_len, remain_m1;
    logic n_all_sent, n_all_cancel, n_all_ready;
    logic [RING_DEPTH-1:0] mask_n;
    logic [7:0] first_gtag, first_ctag;
    logic [PTR_W-1:0] first_pos;
    logic [CNT_W:0] add_sum;
    logic emit_req, end_cmd, to_retire, stall, can_emit, emit_fire, held_move, out_free;
    res_t emit_res;

    assign sid_ok = (int'(cmd_reg.slot_id) < RING_DEPTH);
    assign rd_addr = (state_reg == S_CONFIRM) ? PTR_W'(cmd_reg.slot_id) : pos_reg;
    assign rd_status = status_reg[rd_addr];
    assign rd_group = group_mem[rd_addr];
    assign rd_cancel = cancel_mem[rd_addr];
    assign rd_last = last_mem[rd_addr];
    assign full = (used_reg == CNT_W'(RING_DEPTH));
    assign pos_inc = (pos_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
    assign free_inc = (free_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : free_reg + 1'b1;
    assign new_len = len_reg + 1'b1;
    assign remain_m1 = remain_reg - 1'b1;
    assign n_all_sent = all_sent_reg && (rd_status == SL_SENT);
    assign n_all_cancel = all_cancel_reg && (rd_status == SL_CANCEL);
    assign n_all_ready = all_ready_reg && (rd_status == SL_READY);
    assign mask_n = mask_reg | ({{(RING_DEPTH-1){1'b0}}, 1'b1} << pos_reg);
    assign first_gtag = (len_reg == '0) ? rd_group : gtag_reg;
    assign first_ctag = (len_reg == '0) ? rd_cancel : ctag_reg;
    assign first_pos = (len_reg == '0) ? pos_reg : start_reg;
    assign grp_end = rd_last || (remain_m1 == '0);
    assign walk_stop = (len_reg == '0)
        && ((remain_reg == '0) || (n_reg == NRES_W'(MaxResults)));
    assign add_sum = (CNT_W+1)'(oldest_reg) + (CNT_W+1)'(new_len);
    assign old_add = (add_sum >= (CNT_W+1)'(RING_DEPTH))
        ? PTR_W'(add_sum - (CNT_W+1)'(RING_DEPTH)) : PTR_W'(add_sum);
    assign out_free = !out_valid_reg || res.ready;
    assign can_emit = !held_valid_reg || out_free;
    assign stall = emit_req && !can_emit;
    assign emit_fire = emit_req && can_emit;
    assign held_move = held_valid_reg && out_free && (held_final_reg || emit_fire);

    always_comb
    begin
        emit_req = 1'b0;
        end_cmd = 1'b0;
        to_retire = 1'b0;
        emit_res.status = RS_IGNORED;
        emit_res.slot_index = 4'd0;
        emit_res.packet_tag = 8'd0;
        emit_res.sent_total = sent_reg;
        case (state_reg)
            S_ENQ:
            begin
                emit_req = 1'b1;
                end_cmd = 1'b1;
                emit_res.packet_tag = cmd_reg.group_tag;
                if (full)
                begin
                    emit_res.status = RS_FULL;
                end
                else
                begin
                    emit_res.status = RS_ACCEPTED;
                    emit_res.slot_index = 4'(free_reg);
                end
            end
            S_FETCH:
            begin
                if (remain_reg == '0)
                begin
                    emit_req = 1'b1;
                    end_cmd = 1'b1;
                    emit_res.status = RS_NOTHING;
                end
                else if (rd_status == SL_READY)
                begin
                    emit_req = 1'b1;
                    end_cmd = 1'b1;
                    emit_res.status = RS_FETCHED;
                    emit_res.slot_index = 4'(pos_reg);
                    emit_res.packet_tag = rd_group;
                end
            end
            S_CONFIRM:
            begin
                if (!sid_ok || rd_status != SL_PENDING)
                begin
                    emit_req = 1'b1;
                    end_cmd = 1'b1;
                end
                else
                begin
                    to_retire = 1'b1;
                end
            end
            S_BAD:
            begin
                emit_req = 1'b1;
                end_cmd = 1'b1;
            end
            S_RETIRE:
            begin
                if (walk_stop)
                begin
                    end_cmd = 1'b1;
                end
                else if (grp_end)
                begin
                    if (!rd_last)
                    begin
                        end_cmd = 1'b1;
                    end
                    else if (n_all_sent)
                    begin
                        emit_req = 1'b1;
                        emit_res.status = RS_COMPLETED;
                        emit_res.slot_index = 4'(first_pos);
                        emit_res.packet_tag = first_gtag;
                        emit_res.sent_total = sent_reg + 32'(new_len);
                    end
                    else if (!n_all_cancel)
                    begin
                        end_cmd = 1'b1;
                    end
                end
            end
            S_CANCEL:
            begin
                if (walk_stop)
                begin
                    to_retire = 1'b1;
                end
                else if (grp_end && rd_last && first_ctag == cmd_reg.cancel_tag
                         && n_all_ready)
                begin
                    emit_req = 1'b1;
                    emit_res.status = RS_ABORTED;
                    emit_res.slot_index = 4'(first_pos);
                    emit_res.packet_tag = first_gtag;
                end
            end
            S_DROP:
            begin
                if (walk_stop)
                begin
                    end_cmd = 1'b1;
                end
                else if (grp_end && !n_all_cancel)
                begin
                    emit_req = 1'b1;
                    emit_res.status = RS_PAUSED;
                    emit_res.slot_index = 4'(first_pos);
                    emit_res.packet_tag = first_gtag;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (state_reg == S_IDLE)
        begin
            if (cmd_valid)
            begin
                case (cmd.kind)
                    CMD_ENQUEUE: state_next = S_ENQ;
                    CMD_FETCH:   state_next = S_FETCH;
                    CMD_CONFIRM: state_next = S_CONFIRM;
                    CMD_CANCEL:  state_next = S_CANCEL;
                    CMD_TICK:    state_next = fetched_reg ? S_IDLE : S_DROP;
                    default:     state_next = S_BAD;
                endcase
            end
        end
        else if (!stall)
        begin
            if (to_retire)
            begin
                state_next = S_RETIRE;
            end
            else if (end_cmd)
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_comb
    begin
        cmd_pop = 1'b0;
        cmd_next = cmd_reg;
        status_next = status_reg;
        oldest_next = oldest_reg;
        free_next = free_reg;
        used_next = used_reg;
        fetched_next = fetched_reg;
        sent_next = sent_reg;
        pos_next = pos_reg;
        remain_next = remain_reg;
        len_next = len_reg;
        start_next = start_reg;
        gtag_next = gtag_reg;
        ctag_next = ctag_reg;
        all_sent_next = all_sent_reg;
        all_cancel_next = all_cancel_reg;
        all_ready_next = all_ready_reg;
        mask_next = mask_reg;
        n_next = n_reg;
        if (state_reg == S_IDLE)
        begin
            if (cmd_valid)
            begin
                cmd_pop = 1'b1;
                cmd_next = cmd;
                n_next = '0;
                pos_next = oldest_reg;
                remain_next = used_reg;
                len_next = '0;
                all_sent_next = 1'b1;
                all_cancel_next = 1'b1;
                all_ready_next = 1'b1;
                mask_next = '0;
                if (cmd.kind == CMD_FETCH)
                begin
                    fetched_next = 1'b1;
                end
                else if (cmd.kind == CMD_TICK)
                begin
                    fetched_next = 1'b0;
                end
            end
        end
        else if (!stall)
        begin
            if (emit_fire)
            begin
                n_next = n_reg + 1'b1;
            end
            case (state_reg)
                S_ENQ:
                begin
                    if (!full)
                    begin
                        status_next[free_reg] = SL_READY;
                        free_next = free_inc;
                        used_next = used_reg + 1'b1;
                    end
                end
                S_FETCH:
                begin
                    if (remain_reg != '0)
                    begin
                        if (rd_status == SL_READY)
                        begin
                            status_next[pos_reg] = SL_PENDING;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                            remain_next = remain_m1;
                        end
                    end
                end
                S_CONFIRM:
                begin
                    if (to_retire)
                    begin
                        status_next[PTR_W'(cmd_reg.slot_id)] = SL_SENT;
                    end
                end
                S_RETIRE, S_CANCEL, S_DROP:
                begin
                    if (!walk_stop)
                    begin
                        pos_next = pos_inc;
                        remain_next = remain_m1;
                        start_next = first_pos;
                        gtag_next = first_gtag;
                        ctag_next = first_ctag;
                        if (grp_end)
                        begin
                            len_next = '0;
                            all_sent_next = 1'b1;
                            all_cancel_next = 1'b1;
                            all_ready_next = 1'b1;
                            mask_next = '0;
                            if ((state_reg == S_DROP) || ((state_reg == S_RETIRE)
                                && rd_last && (n_all_sent || n_all_cancel)))
                            begin
                                for (int i = 0; i < RING_DEPTH; i++)
                                begin
                                    if (mask_n[i])
                                    begin
                                        status_next[i] = SL_EMPTY;
                                    end
                                end
                                oldest_next = old_add;
                                used_next = used_reg - new_len;
                                if (state_reg == S_RETIRE && n_all_sent)
                                begin
                                    sent_next = sent_reg + 32'(new_len);
                                end
                            end
                            if (state_reg == S_CANCEL && emit_req)
                            begin
                                for (int i = 0; i < RING_DEPTH; i++)
                                begin
                                    if (mask_n[i])
                                    begin
                                        status_next[i] = SL_CANCEL;
                                    end
                                end
                            end
                        end
                        else
                        begin
                            len_next = new_len;
                            all_sent_next = n_all_sent;
                            all_cancel_next = n_all_cancel;
                            all_ready_next = n_all_ready;
                            mask_next = mask_n;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (to_retire)
            begin
                pos_next = oldest_reg;
                remain_next = used_reg;
                len_next = '0;
                all_sent_next = 1'b1;
                all_cancel_next = 1'b1;
                all_ready_next = 1'b1;
                mask_next = '0;
            end
        end
    end

    always_comb
    begin
        held_next = held_reg;
        held_valid_next = held_valid_reg;
        held_final_next = held_final_reg;
        out_next = out_reg;
        out_final_next = out_final_reg;
        out_valid_next = out_valid_reg;
        if (held_move)
        begin
            out_valid_next = 1'b1;
            out_next = held_reg;
            out_final_next = held_final_reg;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit_fire)
        begin
            held_next = emit_res;
            held_valid_next = 1'b1;
            held_final_next = end_cmd;
        end
        else if (held_move)
        begin
            held_valid_next = 1'b0;
        end
        else if (end_cmd && held_valid_reg)
        begin
            held_final_next = 1'b1;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.status = out_reg.status;
    assign res.slot_index = out_reg.slot_index;
    assign res.packet_tag = out_reg.packet_tag;
    assign res.final_result = out_final_reg;
    assign res.sent_total = out_reg.sent_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                status_reg[i] <= SL_EMPTY;
            end
            oldest_reg <= '0;
            free_reg <= '0;
            used_reg <= '0;
            fetched_reg <= 1'b0;
            sent_reg <= '0;
            n_reg <= '0;
            held_valid_reg <= 1'b0;
            held_final_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            status_reg <= status_next;
            oldest_reg <= oldest_next;
            free_reg <= free_next;
            used_reg <= used_next;
            fetched_reg <= fetched_next;
            sent_reg <= sent_next;
            n_reg <= n_next;
            held_valid_reg <= held_valid_next;
            held_final_reg <= held_final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        pos_reg <= pos_next;
        remain_reg <= remain_next;
        len_reg <= len_next;
        start_reg <= start_next;
        gtag_reg <= gtag_next;
        ctag_reg <= ctag_next;
        all_sent_reg <= all_sent_next;
        all_cancel_reg <= all_cancel_next;
        all_ready_reg <= all_ready_next;
        mask_reg <= mask_next;
        held_reg <= held_next;
        out_reg <= out_next;
        out_final_reg <= out_final_next;
        if (state_reg == S_ENQ && !full && !stall)
        begin
            group_mem[free_reg] <= cmd_reg.group_tag;
            cancel_mem[free_reg] <= cmd_reg.cancel_tag;
            last_mem[free_reg] <= cmd_reg.end_of_group;
        end
    end
endmodule
`default_nettype wire

### design/send_completion_queue_top.sv
// Send completion queue top level: request front end, queue and slot walker back end.
// Enqueue and bad requests pass the front queue, the command register and the held and output result registers.
// Fetch scans from the oldest slot, stepping past non-ready slots to the first ready one.
// Confirm, cancel and drop walk the ring one slot per cycle unless a result is stalled, one result per slot at most.
// The front queue holds two requests, so requests are taken while the back end works.
// Reset empties the ring and clears the pointers and the sent counter.
`default_nettype none
module send_completion_queue_top
    import scq_pkg::*;
#(
    parameter int RING_DEPTH = RingDepthDefault
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    scq_in_if.sink    req,
    scq_out_if.source res
);
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    scq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    scq_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .res       (res)
    );
endmodule
`default_nettype wire

### tb/sv/scq_tb_if.sv
// Interfaces are taken from the design; this file holds the testbench request and result item types.
`timescale 1ns / 100ps
package scq_tb_pkg;
    typedef struct {
        logic [2:0] action;
        logic [7:0] group_tag;
        logic [7:0] cancel_tag;
        logic end_of_group;
        logic [3:0] slot_id;
    } scq_req_t;

    typedef struct {
        logic [2:0] status;
        logic [3:0] slot_index;
        logic [7:0] packet_tag;
        logic final_result;
        logic [31:0] sent_total;
    } scq_res_t;
endpackage

### tb/sv/tb_send_completion_queue_top.sv
// Testbench of the send completion queue top level with a self-checking queue predictor.
`timescale 1ns / 100ps
module tb_send_completion_queue_top;
    import scq_pkg::*;
    import scq_tb_pkg::*;

    localparam int Depth = 16;
    localparam int IdleLimit = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    scq_in_if req ();
    scq_out_if res ();

    send_completion_queue_top u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .res(res.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    slot_st_t ring_st [Depth];
    logic [7:0] ring_grp [Depth];
    logic [7:0] ring_cxl [Depth];
    logic ring_end [Depth];
    int oldest_slot;
    int used_count;
    int free_slot;
    bit fetched_flag;
    logic [31:0] sent_count;

    scq_res_t expected_results[$];
    scq_res_t step_results[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int sent_rate = 26;
    int recv_rate = 26;
    bit recv_hold = 1'b0;
    bit timed_out = 1'b0;
    logic [7:0] last_tags[$];

    function automatic int wrap(int p);
        return p % Depth;
    endfunction

    function automatic void add_result(logic [2:0] st, int slot, logic [7:0] tag);
        scq_res_t r;
        r.status = st;
        r.slot_index = slot[3:0];
        r.packet_tag = tag;
        r.final_result = 1'b0;
        r.sent_total = sent_count;
        step_results.push_back(r);
    endfunction

    function automatic int span_of(int start, int remain, output bit closed);
        int len;
        int i;
        len = 0;
        i = start;
        closed = 1'b0;
        while (len < remain)
        begin
            len++;
            if (ring_end[i])
            begin
                closed = 1'b1;
                return len;
            end
            i = wrap(i + 1);
        end
        return len;
    endfunction

    function automatic bit all_in(int start, int len, slot_st_t st);
        for (int k = 0; k < len; k++)
            if (ring_st[wrap(start + k)] != st)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void set_all(int start, int len, slot_st_t st);
        for (int k = 0; k < len; k++)
            ring_st[wrap(start + k)] = st;
    endfunction

    function automatic void pop_oldest(int len);
        set_all(oldest_slot, len, SL_EMPTY);
        oldest_slot = wrap(oldest_slot + len);
        used_count -= len;
    endfunction

    function automatic void retire_groups();
        bit closed;
        int start;
        int len;
        while (used_count > 0 && step_results.size() < MaxResults)
        begin
            start = oldest_slot;
            len = span_of(start, used_count, closed);
            if (!closed)
                break;
            if (all_in(start, len, SL_SENT))
            begin
                sent_count += len;
                add_result(RS_COMPLETED, start, ring_grp[start]);
            end
            else if (!all_in(start, len, SL_CANCEL))
                break;
            pop_oldest(len);
        end
    endfunction

    function automatic void reset_queue_model();
        for (int i = 0; i < Depth; i++)
        begin
            ring_st[i] = SL_EMPTY;
            ring_end[i] = 1'b0;
        end
        oldest_slot = 0;
        used_count = 0;
        free_slot = 0;
        fetched_flag = 1'b0;
        sent_count = 0;
    endfunction

    function automatic void predict_queue(scq_req_t q);
        bit closed;
        bit found;
        int s;
        int pos;
        int remain;
        int len;
        step_results.delete();
        case (q.action)
            ACT_ENQUEUE:
            begin
                if (used_count >= Depth)
                    add_result(RS_FULL, 0, q.group_tag);
                else
                begin
                    s = free_slot;
                    ring_st[s] = SL_READY;
                    ring_grp[s] = q.group_tag;
                    ring_cxl[s] = q.cancel_tag;
                    ring_end[s] = q.end_of_group;
                    free_slot = wrap(s + 1);
                    used_count++;
                    add_result(RS_ACCEPTED, s, q.group_tag);
                end
            end
            ACT_FETCH:
            begin
                found = 1'b0;
                s = 0;
                fetched_flag = 1'b1;
                for (int k = 0; k < used_count; k++)
                begin
                    s = wrap(oldest_slot + k);
                    if (ring_st[s] == SL_READY)
                    begin
                        found = 1'b1;
                        break;
                    end
                end
                if (found)
                begin
                    ring_st[s] = SL_PENDING;
                    add_result(RS_FETCHED, s, ring_grp[s]);
                end
                else
                    add_result(RS_NOTHING, 0, 8'd0);
            end
            ACT_CONFIRM:
            begin
                if (ring_st[q.slot_id] != SL_PENDING)
                    add_result(RS_IGNORED, 0, 8'd0);
                else
                begin
                    ring_st[q.slot_id] = SL_SENT;
                    retire_groups();
                end
            end
            ACT_CANCEL:
            begin
                pos = oldest_slot;
                remain = used_count;
                while (remain > 0 && step_results.size() < MaxResults)
                begin
                    len = span_of(pos, remain, closed);
                    if (closed && ring_cxl[pos] == q.cancel_tag && all_in(pos, len, SL_READY))
                    begin
                        set_all(pos, len, SL_CANCEL);
                        add_result(RS_ABORTED, pos, ring_grp[pos]);
                    end
                    pos = wrap(pos + len);
                    remain -= len;
                end
                retire_groups();
            end
            ACT_TICK:
            begin
                if (fetched_flag)
                    fetched_flag = 1'b0;
                else
                begin
                    while (used_count > 0 && step_results.size() < MaxResults)
                    begin
                        len = span_of(oldest_slot, used_count, closed);
                        if (!all_in(oldest_slot, len, SL_CANCEL))
                            add_result(RS_PAUSED, oldest_slot, ring_grp[oldest_slot]);
                        pop_oldest(len);
                    end
                end
            end
            default:
                add_result(RS_IGNORED, 0, 8'd0);
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].final_result = 1'b1;
        foreach (step_results[i])
            expected_results.push_back(step_results[i]);
    endfunction

    task automatic send_request(logic [2:0] act, logic [7:0] gtag, logic [7:0] ctag,
                                logic eog, logic [3:0] sid);
        scq_req_t q;
        q.action = act;
        q.group_tag = gtag;
        q.cancel_tag = ctag;
        q.end_of_group = eog;
        q.slot_id = sid;
        while ($urandom_range(99) < sent_rate)
            @(negedge clk);
        req.valid = 1'b1;
        req.action = act;
        req.group_tag = gtag;
        req.cancel_tag = ctag;
        req.end_of_group = eog;
        req.slot_id = sid;
        do
            @(posedge clk);
        while (!req.ready);
        predict_queue(q);
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() > 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic enqueue_one(logic eog, logic [7:0] ctag);
        send_request(ACT_ENQUEUE, 8'($urandom), ctag, eog, 4'($urandom));
    endtask

    task automatic fetch_one();
        send_request(ACT_FETCH, 8'($urandom), 8'($urandom), 1'($urandom), 4'($urandom));
    endtask

    task automatic confirm_slot(logic [3:0] sid);
        send_request(ACT_CONFIRM, 8'($urandom), 8'($urandom), 1'($urandom), sid);
    endtask

    task automatic cancel_tag_req(logic [7:0] ctag);
        send_request(ACT_CANCEL, 8'($urandom), ctag, 1'($urandom), 4'($urandom));
    endtask

    task automatic tick_one();
        send_request(ACT_TICK, 8'($urandom), 8'($urandom), 1'($urandom), 4'($urandom));
    endtask

    function automatic logic [3:0] pending_slot();
        for (int k = 0; k < used_count; k++)
            if (ring_st[wrap(oldest_slot + k)] == SL_PENDING)
                return 4'(wrap(oldest_slot + k));
        return 4'($urandom);
    endfunction

    task automatic test_directed();
        send_request(ACT_ENQUEUE, 8'hff, 8'h00, 1'b0, 4'hf);
        send_request(ACT_ENQUEUE, 8'h00, 8'hff, 1'b1, 4'h0);
        fetch_one();
        confirm_slot(4'd0);
        confirm_slot(4'd15);
        fetch_one();
        confirm_slot(4'd1);
        fetch_one();
        send_request(3'd5, 8'h00, 8'h00, 1'b0, 4'h0);
        send_request(3'd7, 8'hff, 8'hff, 1'b1, 4'hf);
        for (int i = 0; i < 17; i++)
            send_request(ACT_ENQUEUE, 8'(i), 8'h5a, 1'b1, 4'h0);
        cancel_tag_req(8'h5a);
        tick_one();
        wait_drained();
    endtask

    task automatic test_drop_paused();
        for (int i = 0; i < 6; i++)
            enqueue_one(1'($urandom_range(1)), 8'($urandom_range(3)));
        fetch_one();
        tick_one();
        tick_one();
        wait_drained();
    endtask

    task automatic test_backpressure();
        recv_hold = 1'b1;
        for (int i = 0; i < 12; i++)
            enqueue_one(1'b1, 8'h11);
        cancel_tag_req(8'h11);
        for (int i = 0; i < 6; i++)
            fetch_one();
        wait_drained();
        tick_one();
        tick_one();
        wait_drained();
    endtask

    task automatic test_random_flow(int count, int rate);
        int pick;
        sent_rate = rate;
        recv_rate = rate;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                enqueue_one(1'($urandom_range(2) == 0), 8'($urandom_range(3)));
            else if (pick < 60)
                fetch_one();
            else if (pick < 82)
                confirm_slot($urandom_range(3) == 0 ? 4'($urandom) : pending_slot());
            else if (pick < 90)
                cancel_tag_req(8'($urandom_range(3) == 0 ? $urandom : $urandom_range(3)));
            else if (pick < 97)
                tick_one();
            else
                send_request(3'($urandom_range(7, 5)), 8'($urandom), 8'($urandom),
                             1'($urandom), 4'($urandom));
        end
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (recv_hold)
            res.ready <= 1'b0;
        else
            res.ready <= ($urandom_range(99) >= recv_rate);
    end

    initial
    begin
        int hold;
        wait (recv_hold);
        for (hold = 0; hold < 150; hold++)
            @(posedge clk);
        recv_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        scq_res_t e;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d slot=%0d", res.status,
                             res.slot_index);
            end
            else
            begin
                e = expected_results.pop_front();
                if (res.status !== e.status || res.slot_index !== e.slot_index ||
                    res.packet_tag !== e.packet_tag || res.final_result !== e.final_result ||
                    res.sent_total !== e.sent_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp st=%0d sl=%0d tag=%h fin=%0b tot=%0d got st=%0d sl=%0d tag=%h fin=%0b tot=%0d",
                                 e.status, e.slot_index, e.packet_tag, e.final_result,
                                 e.sent_total, res.status, res.slot_index, res.packet_tag,
                                 res.final_result, res.sent_total);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tb_send_completion_queue_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.action = ACT_ENQUEUE;
        req.group_tag = 8'd0;
        req.cancel_tag = 8'd0;
        req.end_of_group = 1'b0;
        req.slot_id = 4'd0;
        res.ready = 1'b0;
        reset_queue_model();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_drop_paused();
        test_backpressure();
        test_random_flow(60, 0);
        test_random_flow(150, 26);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_send_completion_queue_top: PASS");
        else
            $display("tb_send_completion_queue_top: FAIL");
        $finish;
    end
endmodule
